[hdl/tile_grid_box_collision_assert.svh]
// Assertion macros for the tile grid box collision block.
`ifndef TILE_GRID_BOX_COLLISION_ASSERT_SVH
`define TILE_GRID_BOX_COLLISION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGBC_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile grid box collision check failed");

// The consequent must hold in the cycle after the antecedent.
`define TGBC_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile grid box collision check failed");

`endif

[hdl/tgbc_pkg.sv]
package tgbc_pkg;

  localparam int MAP_CELLS = 4096;
  localparam int CELL_AW   = $clog2(MAP_CELLS);
  localparam int CRD_W     = 16;
  localparam int MAG_W     = 15;
  localparam int DIV_W     = 7;
  localparam int MOV_W     = 9;
  localparam int PROD_W    = 26;
  localparam int IDX_W     = 27;
  localparam int CNT_W     = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    CFG_TILE_WIDTH  = 2'd0,
    CFG_TILE_HEIGHT = 2'd1,
    CFG_MAP_WIDTH   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_IDX,
    ST_RD,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SLOT_MOVE,
    SLOT_FIX_A,
    SLOT_FIX_B
  } slot_t;

  typedef struct packed {
    logic  clear_wr;
    logic  load_wr;
    logic  capture;
    logic  horiz;
    logic  pass_start;
    slot_t slot;
    logic  div_start;
    logic  div_store;
    logic  mul;
    logic  idx;
    logic  step;
    logic  fin_hit;
    logic  fin_want;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic want_zero;
    logic div_done;
    logic hit;
    logic last_step;
  } stat_t;

endpackage

[hdl/tgbc_ram.sv]
module tgbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/tgbc_div.sv]
module tgbc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tgbc_pkg::MAG_W-1:0] dividend,
  input  logic [tgbc_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [tgbc_pkg::MAG_W-1:0] quo,
  output logic [tgbc_pkg::DIV_W-1:0] rem
);

  logic                       busy;
  logic [tgbc_pkg::CNT_W-1:0] cnt;
  logic [tgbc_pkg::DIV_W-1:0] dvs;
  logic [tgbc_pkg::DIV_W:0]   shifted;
  logic [tgbc_pkg::DIV_W:0]   diff;
  logic                       ge;

  assign shifted = {rem, quo[tgbc_pkg::MAG_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tgbc_pkg::CNT_W'(tgbc_pkg::MAG_W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[tgbc_pkg::DIV_W-1:0] : shifted[tgbc_pkg::DIV_W-1:0];
        quo <= {quo[tgbc_pkg::MAG_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == tgbc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/tgbc_dp.sv]
module tgbc_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [8:0]               cfg_data,
  input  logic [11:0]              cell_index,
  input  logic                     cell_blocked,
  input  logic [13:0]              pos_x,
  input  logic [13:0]              pos_y,
  input  logic [7:0]               box_width,
  input  logic [7:0]               box_height,
  input  logic signed [8:0]        move_x,
  input  logic signed [8:0]        move_y,
  input  tgbc_pkg::cmd_t           cmd,
  output tgbc_pkg::stat_t          stat,
  output logic signed [8:0]        allowed_x,
  output logic signed [8:0]        allowed_y
);

  localparam int CW = tgbc_pkg::CRD_W;

  logic [6:0] tile_w;
  logic [6:0] tile_h;
  logic [8:0] map_w;

  logic [13:0]       px, py;
  logic [7:0]        bw, bh;
  logic signed [8:0] mx, my;
  logic signed [8:0] ay_res, ax_res;
  logic signed [8:0] off, off_next;

  logic signed [CW-1:0] mq, fa, fb, mt;
  logic [6:0]           mr, md, dreg;
  logic                 dsign;

  logic signed [tgbc_pkg::PROD_W-1:0] prod_a, prod_b;
  logic signed [CW-1:0]               col_a_r, col_b_r;
  logic signed [tgbc_pkg::IDX_W-1:0]  idx_a, idx_b;
  logic [tgbc_pkg::CELL_AW-1:0]       clr_cnt;

  logic signed [8:0]    want, res;
  logic                 neg;
  logic signed [CW-1:0] px_s, py_s, bw_s, bh_s, ay_s;
  logic signed [CW-1:0] move_base, fix_a, fix_b, div_val, div_abs;
  logic signed [CW-1:0] row_a, row_b, col_a, col_b, q_pos;
  logic [6:0]           dsel, d_eff;
  logic                 use_w, div_neg, div_done, oob_a, oob_b, rd_a, rd_b;
  logic [tgbc_pkg::MAG_W-1:0] quo;
  logic [6:0]                 rem;

  logic                         ram_we;
  logic [tgbc_pkg::CELL_AW-1:0] ram_waddr;
  logic                         ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_w <= 7'd16;
      tile_h <= 7'd16;
      map_w  <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        tgbc_pkg::CFG_TILE_WIDTH:  tile_w <= cfg_data[6:0];
        tgbc_pkg::CFG_TILE_HEIGHT: tile_h <= cfg_data[6:0];
        tgbc_pkg::CFG_MAP_WIDTH:   map_w  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign want = cmd.horiz ? mx : my;
  assign neg  = want[8];
  assign px_s = $signed({2'b00, px});
  assign py_s = $signed({2'b00, py});
  assign bw_s = $signed({8'd0, bw});
  assign bh_s = $signed({8'd0, bh});
  assign ay_s = {{(CW - 9){ay_res[8]}}, ay_res};

  always_comb begin
    if (cmd.horiz) begin
      move_base = px_s + (neg ? CW'(0) : bw_s);
      fix_a     = py_s + ay_s;
      fix_b     = py_s + ay_s + bh_s;
    end else begin
      move_base = py_s + (neg ? CW'(0) : bh_s);
      fix_a     = px_s;
      fix_b     = px_s + bw_s;
    end
    case (cmd.slot)
      tgbc_pkg::SLOT_MOVE:  div_val = move_base;
      tgbc_pkg::SLOT_FIX_A: div_val = fix_a;
      tgbc_pkg::SLOT_FIX_B: div_val = fix_b;
      default:              div_val = move_base;
    endcase
    div_neg = div_val[CW-1];
    div_abs = div_neg ? -div_val : div_val;
    use_w   = (cmd.slot == tgbc_pkg::SLOT_MOVE) ? cmd.horiz : !cmd.horiz;
    dsel    = use_w ? tile_w : tile_h;
    d_eff   = (dsel == 7'd0) ? 7'd1 : dsel;
  end

  tgbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_abs[tgbc_pkg::MAG_W-1:0]),
    .divisor  (d_eff),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign q_pos    = $signed({1'b0, quo});
  assign mt       = mq + (((mq < 0) && (mr != 7'd0)) ? CW'(1) : CW'(0));
  assign row_a    = cmd.horiz ? fa : mt;
  assign row_b    = cmd.horiz ? fb : mt;
  assign col_a    = cmd.horiz ? mt : fa;
  assign col_b    = cmd.horiz ? mt : fb;
  assign off_next = neg ? off - 9'sd1 : off + 9'sd1;
  assign res      = cmd.fin_hit ? (neg ? off + 9'sd1 : off - 9'sd1) : want;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pos_x;
      py <= pos_y;
      bw <= box_width;
      bh <= box_height;
      mx <= move_x;
      my <= move_y;
    end
    if (cmd.div_start) begin
      dsign <= div_neg;
      dreg  <= d_eff;
    end
    if (cmd.div_store) begin
      case (cmd.slot)
        tgbc_pkg::SLOT_MOVE: begin
          md <= dreg;
          if (!dsign) begin
            mq <= q_pos;
            mr <= rem;
          end else if (rem == 7'd0) begin
            mq <= -q_pos;
            mr <= 7'd0;
          end else begin
            mq <= -q_pos - CW'(1);
            mr <= dreg - rem;
          end
        end
        tgbc_pkg::SLOT_FIX_A: fa <= dsign ? -q_pos : q_pos;
        tgbc_pkg::SLOT_FIX_B: fb <= dsign ? -q_pos : q_pos;
        default: ;
      endcase
    end
    if (cmd.mul) begin
      prod_a  <= tgbc_pkg::PROD_W'(row_a) * tgbc_pkg::PROD_W'($signed({1'b0, map_w}));
      prod_b  <= tgbc_pkg::PROD_W'(row_b) * tgbc_pkg::PROD_W'($signed({1'b0, map_w}));
      col_a_r <= col_a;
      col_b_r <= col_b;
    end
    if (cmd.idx) begin
      idx_a <= tgbc_pkg::IDX_W'(prod_a) + tgbc_pkg::IDX_W'(col_a_r);
      idx_b <= tgbc_pkg::IDX_W'(prod_b) + tgbc_pkg::IDX_W'(col_b_r);
    end
    if (cmd.pass_start) begin
      off <= 9'sd0;
    end else if (cmd.step) begin
      off <= off_next;
      if (!neg) begin
        if (mr == md - 7'd1) begin
          mq <= mq + CW'(1);
          mr <= 7'd0;
        end else begin
          mr <= mr + 7'd1;
        end
      end else begin
        if (mr == 7'd0) begin
          mq <= mq - CW'(1);
          mr <= md - 7'd1;
        end else begin
          mr <= mr - 7'd1;
        end
      end
    end
    if (cmd.fin_hit || cmd.fin_want) begin
      if (cmd.horiz) begin
        ax_res <= res;
      end else begin
        ay_res <= res;
      end
    end
    if (cmd.out_load) begin
      allowed_x <= ax_res;
      allowed_y <= ay_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign ram_we    = cmd.clear_wr || (cmd.load_wr && (int'(cell_index) < tgbc_pkg::MAP_CELLS));
  assign ram_waddr = cmd.clear_wr ? clr_cnt : tgbc_pkg::CELL_AW'(cell_index);
  assign ram_wdata = cmd.clear_wr ? 1'b0 : cell_blocked;

  tgbc_ram #(
    .WIDTH (1),
    .DEPTH (tgbc_pkg::MAP_CELLS)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (idx_a[tgbc_pkg::CELL_AW-1:0]),
    .raddr_b (idx_b[tgbc_pkg::CELL_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign oob_a = idx_a[tgbc_pkg::IDX_W-1] || (idx_a >= tgbc_pkg::IDX_W'(tgbc_pkg::MAP_CELLS));
  assign oob_b = idx_b[tgbc_pkg::IDX_W-1] || (idx_b >= tgbc_pkg::IDX_W'(tgbc_pkg::MAP_CELLS));

  assign stat.clear_last = clr_cnt == tgbc_pkg::CELL_AW'(tgbc_pkg::MAP_CELLS - 1);
  assign stat.want_zero  = want == 9'sd0;
  assign stat.div_done   = div_done;
  assign stat.hit        = oob_a || rd_a || oob_b || rd_b;
  assign stat.last_step  = off_next == want;

endmodule

[hdl/tgbc_ctrl.sv]
module tgbc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            mode,
  output logic            item_stall,
  output logic            res_valid,
  input  logic            res_stall,
  input  tgbc_pkg::stat_t stat,
  output tgbc_pkg::cmd_t  cmd
);

  tgbc_pkg::state_t state, state_next;
  tgbc_pkg::slot_t  slot, slot_next;
  logic             horiz, horiz_next;
  logic             res_valid_next;
  logic             end_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tgbc_pkg::ST_CLEAR;
      slot      <= tgbc_pkg::SLOT_MOVE;
      horiz     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      slot      <= slot_next;
      horiz     <= horiz_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    slot_next      = slot;
    horiz_next     = horiz;
    res_valid_next = res_valid && res_stall;
    end_pass       = 1'b0;
    cmd            = '0;
    cmd.horiz      = horiz;
    cmd.slot       = slot;
    case (state)
      tgbc_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = tgbc_pkg::ST_IDLE;
        end
      end
      tgbc_pkg::ST_IDLE: begin
        cmd.load_wr = item_valid && !mode;
        cmd.capture = item_valid && mode;
        if (item_valid && mode) begin
          horiz_next = 1'b0;
          state_next = tgbc_pkg::ST_PASS;
        end
      end
      tgbc_pkg::ST_PASS: begin
        cmd.pass_start = 1'b1;
        if (stat.want_zero) begin
          cmd.fin_want = 1'b1;
          end_pass     = 1'b1;
        end else begin
          slot_next  = tgbc_pkg::SLOT_MOVE;
          state_next = tgbc_pkg::ST_DIV_GO;
        end
      end
      tgbc_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = tgbc_pkg::ST_DIV_WAIT;
      end
      tgbc_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (slot == tgbc_pkg::SLOT_FIX_B) begin
            state_next = tgbc_pkg::ST_MUL;
          end else begin
            slot_next  = (slot == tgbc_pkg::SLOT_MOVE) ? tgbc_pkg::SLOT_FIX_A
                                                       : tgbc_pkg::SLOT_FIX_B;
            state_next = tgbc_pkg::ST_DIV_GO;
          end
        end
      end
      tgbc_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = tgbc_pkg::ST_IDX;
      end
      tgbc_pkg::ST_IDX: begin
        cmd.idx    = 1'b1;
        state_next = tgbc_pkg::ST_RD;
      end
      tgbc_pkg::ST_RD: begin
        state_next = tgbc_pkg::ST_EVAL;
      end
      tgbc_pkg::ST_EVAL: begin
        if (stat.hit) begin
          cmd.fin_hit = 1'b1;
          end_pass    = 1'b1;
        end else if (stat.last_step) begin
          cmd.fin_want = 1'b1;
          end_pass     = 1'b1;
        end else begin
          cmd.step   = 1'b1;
          state_next = tgbc_pkg::ST_MUL;
        end
      end
      tgbc_pkg::ST_DONE: begin
        if (!res_valid || !res_stall) begin
          cmd.out_load   = 1'b1;
          res_valid_next = 1'b1;
          state_next     = tgbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tgbc_pkg::ST_IDLE;
      end
    endcase
    if (end_pass) begin
      if (!horiz) begin
        horiz_next = 1'b1;
        state_next = tgbc_pkg::ST_PASS;
      end else begin
        state_next = tgbc_pkg::ST_DONE;
      end
    end
  end

  assign item_stall = state != tgbc_pkg::ST_IDLE;

endmodule

[hdl/tile_grid_box_collision.sv]
// Box against tile map collision, resolved one pixel at a time.
// Input items arrive on item_valid / item_stall. A load item (mode 0) writes one
// cell of the blocked map in the cycle it is accepted and gives no result. A query
// item (mode 1) returns one result item, allowed_x and allowed_y, on res_valid /
// res_stall; the vertical move is resolved first, then the horizontal move.
// An axis with a nonzero move costs three tile divisions on a shared radix-2 divider
// and then, for each pixel tested, a multiply, index, map read and test step; an axis
// with no move skips the divisions and the pixel tests.
// One query is worked on at a time; a finished result sits in an output register
// while the next item is taken.
// Configuration writes on cfg_we take effect at once and belong to idle periods.
// After reset all 4096 cells of the map are swept clear, during which item_stall
// stays high. A stalled result holds its value until it is taken.
`include "tile_grid_box_collision_assert.svh"

module tile_grid_box_collision (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              mode,
  input  logic [11:0]       cell_index,
  input  logic              cell_blocked,
  input  logic [13:0]       pos_x,
  input  logic [13:0]       pos_y,
  input  logic [7:0]        box_width,
  input  logic [7:0]        box_height,
  input  logic signed [8:0] move_x,
  input  logic signed [8:0] move_y,
  output logic              res_valid,
  input  logic              res_stall,
  output logic signed [8:0] allowed_x,
  output logic signed [8:0] allowed_y
);

  tgbc_pkg::cmd_t  cmd;
  tgbc_pkg::stat_t stat;

  tgbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .mode       (mode),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  tgbc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_index   (cell_index),
    .cell_blocked (cell_blocked),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .move_x       (move_x),
    .move_y       (move_y),
    .cmd          (cmd),
    .stat         (stat),
    .allowed_x    (allowed_x),
    .allowed_y    (allowed_y)
  );

  `TGBC_CHECK_NEXT(a_query_busy, item_valid && !item_stall && mode, item_stall)
  `TGBC_CHECK_NEXT(a_load_single, item_valid && !item_stall && !mode, !item_stall)
  `TGBC_CHECK_NOW(a_result_after_work, $rose(res_valid), $past(item_stall))

endmodule

[tb/tile_grid_box_collision_test.sv]
module tile_grid_box_collision_test;

  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic signed [8:0] ax;
    logic signed [8:0] ay;
  } move_pair_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [8:0]        cfg_data = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              mode = 1'b0;
  logic [11:0]       cell_index = '0;
  logic              cell_blocked = 1'b0;
  logic [13:0]       pos_x = '0;
  logic [13:0]       pos_y = '0;
  logic [7:0]        box_width = '0;
  logic [7:0]        box_height = '0;
  logic signed [8:0] move_x = '0;
  logic signed [8:0] move_y = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic signed [8:0] allowed_x;
  logic signed [8:0] allowed_y;

  bit         solid_map [tgbc_pkg::MAP_CELLS];
  int unsigned tile_w, tile_h, map_w;
  move_pair_t pending_moves [$];
  int         errors;
  int         idle_pct;
  int         stall_pct;
  longint     cycles;

  tile_grid_box_collision uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** tile_grid_box_collision: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  function automatic bit tile_solid(input longint row, input longint col);
    longint idx;
    idx = row * longint'(map_w) + col;
    if (idx < 0 || idx >= tgbc_pkg::MAP_CELLS) return 1'b1;
    return solid_map[idx];
  endfunction

  // Steps one axis pixel by pixel; vert selects the vertical pass.
  function automatic longint step_axis(input bit vert, input longint px, input longint py,
                                       input longint bw, input longint bh,
                                       input longint want, input longint other);
    longint tw, th, stp, off, ox, oy, c1, c2, r1, r2, edge_rc;
    bit hit;
    tw = (tile_w == 0) ? 1 : tile_w;
    th = (tile_h == 0) ? 1 : tile_h;
    stp = (want < 0) ? -1 : 1;
    off = 0;
    while (want != 0 && off != want) begin
      ox = vert ? other : off;
      oy = vert ? off : other;
      c1 = (px + ox) / tw;
      c2 = (px + ox + bw) / tw;
      r1 = (py + oy) / th;
      r2 = (py + oy + bh) / th;
      if (vert) begin
        edge_rc = (stp < 0) ? r1 : r2;
        hit = tile_solid(edge_rc, c1) || tile_solid(edge_rc, c2);
      end else begin
        edge_rc = (stp < 0) ? c1 : c2;
        hit = tile_solid(r1, edge_rc) || tile_solid(r2, edge_rc);
      end
      if (hit) return off - stp;
      off += stp;
    end
    return off;
  endfunction

  always @(posedge clk) begin
    move_pair_t exp_mv;
    if (!rst && res_valid && !res_stall) begin
      if (pending_moves.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d", allowed_x, allowed_y));
      end else begin
        exp_mv = pending_moves.pop_front();
        if (allowed_x !== exp_mv.ax)
          report_mismatch($sformatf("allowed_x %0d, expected %0d", allowed_x, exp_mv.ax));
        if (allowed_y !== exp_mv.ay)
          report_mismatch($sformatf("allowed_y %0d, expected %0d", allowed_y, exp_mv.ay));
      end
    end
  end

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic deliver_item(input logic m, input logic [11:0] ci, input logic cb,
                              input logic [13:0] px, input logic [13:0] py,
                              input logic [7:0] bw, input logic [7:0] bh,
                              input logic signed [8:0] mx, input logic signed [8:0] my);
    move_pair_t mv;
    longint ay;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m; cell_index <= ci; cell_blocked <= cb;
    pos_x <= px; pos_y <= py; box_width <= bw; box_height <= bh;
    move_x <= mx; move_y <= my;
    do @(posedge clk); while (item_stall);
    if (!m) begin
      solid_map[ci] = cb;
    end else begin
      ay = step_axis(1'b1, px, py, bw, bh, longint'(my), 0);
      mv.ay = ay[8:0];
      mv.ax = 9'(step_axis(1'b0, px, py, bw, bh, longint'(mx), ay));
      pending_moves.push_back(mv);
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input tgbc_pkg::cfg_idx_t which, input logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      tgbc_pkg::CFG_TILE_WIDTH:  tile_w = val & 9'h7F;
      tgbc_pkg::CFG_TILE_HEIGHT: tile_h = val & 9'h7F;
      default:                   map_w = val;
    endcase
  endtask

  task automatic apply_geometry(input logic [8:0] tw, input logic [8:0] th,
                                input logic [8:0] mw);
    drain_results();
    write_reg(tgbc_pkg::CFG_TILE_WIDTH, tw);
    write_reg(tgbc_pkg::CFG_TILE_HEIGHT, th);
    write_reg(tgbc_pkg::CFG_MAP_WIDTH, mw);
  endtask

  task automatic test_directed();
    deliver_item(1'b0, 12'd0, 1'b1, '0, '0, '0, '0, '0, '0);
    deliver_item(1'b0, 12'd4095, 1'b1, '0, '0, '0, '0, '0, '0);
    deliver_item(1'b0, 12'd130, 1'b1, '0, '0, '0, '0, '0, '0);
    deliver_item(1'b0, 12'd200, 1'b1, '0, '0, '0, '0, '0, '0);
    deliver_item(1'b0, 12'd0, 1'b0, '0, '0, '0, '0, '0, '0);
    // Zero move on both axes.
    deliver_item(1'b1, '0, '0, 14'd100, 14'd100, 8'd4, 8'd4, 9'sd0, 9'sd0);
    // A blocked cell one pixel below the box edge leaves no vertical move at all.
    deliver_item(1'b1, '0, '0, 14'd32, 14'd16, 8'd15, 8'd15, 9'sd0, 9'sd40);
    deliver_item(1'b1, '0, '0, 14'd40, 14'd50, 8'd0, 8'd0, 9'sd120, 9'sd0);
    // Negative pixels round toward zero and stay in row and column zero.
    deliver_item(1'b1, '0, '0, 14'd0, 14'd0, 8'd0, 8'd0, -9'sd30, -9'sd30);
    deliver_item(1'b1, '0, '0, 14'd16383, 14'd16383, 8'd255, 8'd255, 9'sd255, -9'sd256);
    deliver_item(1'b1, '0, '0, 14'd500, 14'd500, 8'd255, 8'd255, -9'sd256, 9'sd255);
    deliver_item(1'b1, '0, '0, 14'd1000, 14'd300, 8'd10, 8'd10, 9'sd255, 9'sd255);
    deliver_item(1'b1, '0, '0, 14'd8191, 14'd0, 8'd128, 8'd127, 9'sd1, -9'sd1);
    deliver_item(1'b1, '0, '0, 14'd0, 14'd8191, 8'd1, 8'd254, -9'sd255, 9'sd128);
    // The right edge column runs over the row end into the next row.
    deliver_item(1'b0, 12'd64, 1'b1, '0, '0, '0, '0, '0, '0);
    deliver_item(1'b1, '0, '0, 14'd1000, 14'd0, 8'd8, 8'd4, 9'sd60, 9'sd0);
    drain_results();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int unsigned span_x, span_y, tw, th;
    logic [13:0] px, py;
    logic signed [8:0] mx, my;
    idle_pct = idle;
    stall_pct = stall;
    tw = (tile_w == 0) ? 1 : tile_w;
    th = (tile_h == 0) ? 1 : tile_h;
    span_x = tw * ((map_w == 0) ? 64 : map_w) + 64;
    span_y = th * ((map_w == 0) ? 64 : (tgbc_pkg::MAP_CELLS / map_w)) + 64;
    if (span_x > 16383) span_x = 16383;
    if (span_y > 16383) span_y = 16383;
    repeat (count) begin
      if ($urandom_range(99) < 45) begin
        deliver_item(1'b0, 12'($urandom), ($urandom_range(99) < 30), 14'($urandom),
                     14'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
                     9'($urandom));
      end else begin
        if ($urandom_range(9) == 0) begin
          px = 14'($urandom);
          py = 14'($urandom);
        end else begin
          px = 14'($urandom_range(span_x));
          py = 14'($urandom_range(span_y));
        end
        if ($urandom_range(4) == 0) begin
          mx = 9'($urandom);
          my = 9'($urandom);
        end else begin
          mx = 9'($signed($urandom_range(80)) - 40);
          my = 9'($signed($urandom_range(80)) - 40);
        end
        deliver_item(1'b1, 12'($urandom), 1'($urandom), px, py,
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40)),
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40)),
                     mx, my);
      end
    end
  endtask

  initial begin
    tile_w = 16;
    tile_h = 16;
    map_w = 64;
    idle_pct = 0;
    stall_pct = 0;
    @(negedge rst);
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    apply_geometry(9'd1, 9'd1, 9'd1);
    test_random(150, 75, 0);
    apply_geometry(9'd64, 9'd64, 9'd256);
    test_random(150, 75, 0);
    apply_geometry(9'd0, 9'h1FF, 9'd0);
    test_random(150, 0, 75);
    apply_geometry(9'd8, 9'd4, 9'd511);
    test_random(150, 0, 75);
    apply_geometry(9'd16, 9'd16, 9'd64);
    test_random(250, 11, 11);
    drain_results();
    if (errors == 0) begin
      $display("** tile_grid_box_collision: PASSED **");
    end else begin
      $display("** tile_grid_box_collision: FAILED **");
    end
    $finish;
  end

endmodule

[tile_grid_box_collision.f]
+incdir+hdl
hdl/tgbc_pkg.sv
hdl/tgbc_ram.sv
hdl/tgbc_div.sv
hdl/tgbc_dp.sv
hdl/tgbc_ctrl.sv
hdl/tile_grid_box_collision.sv
tb/tile_grid_box_collision_test.sv
